>>> src/bbl_pkg.sv
// Shared types and constants for the byte-budget LRU cache directory.
// No dependencies; every other file uses this package.
`default_nettype none
package bbl_pkg;
  localparam int ENTRIES  = 8;
  localparam int NCELL    = ENTRIES + 1;  // last cell stages the new entry
  localparam int STAGE    = ENTRIES;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = $clog2(NCELL);
  localparam int CNT_W    = $clog2(NCELL + 1);
  localparam int EVN_W    = $clog2(ENTRIES + 1);
  localparam int WAIT_LEN = NCELL + 1;
  localparam int WAIT_W   = $clog2(WAIT_LEN);
  localparam logic [31:0] DEFAULT_BUDGET = 32'(16 * 1024 * 1024);
  localparam logic [3:0]  DEFAULT_ENTRIES = 4'd8;

  localparam logic [1:0] ACT_INS  = 2'd0;
  localparam logic [1:0] ACT_LOOK = 2'd1;
  localparam logic [1:0] ACT_REM  = 2'd2;
  localparam logic [1:0] ACT_CLR  = 2'd3;

  localparam logic [2:0] OC_DONE  = 3'd0;
  localparam logic [2:0] OC_HIT   = 3'd1;
  localparam logic [2:0] OC_MISS  = 3'd2;
  localparam logic [2:0] OC_REJ   = 3'd3;
  localparam logic [2:0] OC_EVICT = 3'd4;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MAX_BYTES   = 1'b1;

  typedef struct packed {
    logic clr;
    logic ld;
    logic stamp_ld;
  } cell_ctl_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         bytes;
    logic [31:0]         stamp;
  } wr_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         bytes;
    logic [31:0]         stamp;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [31:0]      stamp;
    logic [IDX_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic                multi;
  } pin_t;

  typedef struct packed {
    logic [2:0]          outcome;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         bytes;
    logic [32:0]         held;
    logic                last;
  } rslt_t;
endpackage
`default_nettype wire

>>> src/bbl_ifs.sv
// Request and result channel interfaces of the cache directory.
// Depends on bbl_pkg for the key width.
`default_nettype none
interface bbl_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [bbl_pkg::KEY_BITS-1:0] entry_key;
  logic [31:0]                  entry_bytes;
  modport source (output valid, action, entry_key, entry_bytes, input ready);
  modport sink   (input valid, action, entry_key, entry_bytes, output ready);
endinterface

interface bbl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   outcome;
  logic [bbl_pkg::KEY_BITS-1:0] out_key;
  logic [31:0]                  out_bytes;
  logic [32:0]                  held_bytes;
  logic                         last;
  modport source (output valid, outcome, out_key, out_bytes, held_bytes, last, input ready);
  modport sink   (input valid, outcome, out_key, out_bytes, held_bytes, last, output ready);
endinterface
`default_nettype wire

>>> src/bbl_cell.sv
// One directory slot: holds an entry and forwards the oldest eligible candidate.
// Depends on bbl_pkg.
`default_nettype none
module bbl_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  [bbl_pkg::IDX_W-1:0]  my_idx,
  input  bbl_pkg::cell_ctl_t         ctl,
  input  bbl_pkg::wr_t               wr,
  input  bbl_pkg::pin_t              pin,
  input  bbl_pkg::cand_t             cand_in,
  output bbl_pkg::entry_t            ent,
  output bbl_pkg::cand_t             cand_out
);
  import bbl_pkg::*;

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0]         bytes_r, stamp_r;
  cand_t               cand_r, cand_nxt;
  logic                elig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.ld) begin
      valid_r <= 1'b1;
    end
    if (ctl.ld) begin
      key_r   <= wr.key;
      bytes_r <= wr.bytes;
    end
    if (ctl.ld || ctl.stamp_ld) begin
      stamp_r <= wr.stamp;
    end
  end

  // skip the pinned key while more than one entry is held
  assign elig = valid_r && !(pin.valid && key_r == pin.key && pin.multi);

  always_comb begin
    cand_nxt = cand_in;
    if (elig && (!cand_in.found || stamp_r < cand_in.stamp)) begin
      cand_nxt.found = 1'b1;
      cand_nxt.stamp = stamp_r;
      cand_nxt.idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign ent      = '{valid: valid_r, key: key_r, bytes: bytes_r, stamp: stamp_r};
  assign cand_out = cand_r;
endmodule
`default_nettype wire

>>> src/bbl_ctrl.sv
// Sequencer of the cache directory: decodes requests, drives the cells, builds results.
// Depends on bbl_pkg; the cell row is wired up by the top level.
`default_nettype none
module bbl_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire                           cfg_idx,
  input  wire  [31:0]                   cfg_data,
  input  wire                           req_valid,
  output logic                          req_ready,
  input  wire  [1:0]                    req_action,
  input  wire  [bbl_pkg::KEY_BITS-1:0]  req_key,
  input  wire  [31:0]                   req_bytes,
  output logic                          rsp_valid,
  input  wire                           rsp_ready,
  output bbl_pkg::rslt_t                rsp,
  input  bbl_pkg::entry_t               ent [bbl_pkg::NCELL],
  input  bbl_pkg::cand_t                cand,
  output bbl_pkg::cell_ctl_t            ctl [bbl_pkg::NCELL],
  output bbl_pkg::wr_t                  wr,
  output bbl_pkg::pin_t                 pin
);
  import bbl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_INS  = 5'b00100,
    S_WAIT = 5'b01000,
    S_EVAL = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          act_r, act_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]         bytes_r, bytes_nxt;
  logic [31:0]         stamp_r, stamp_nxt;
  logic [32:0]         total_r, total_nxt;
  logic [KEY_BITS-1:0] pin_key_r, pin_key_nxt;
  logic                pin_valid_r, pin_valid_nxt;
  logic [3:0]          max_ent_r;
  logic [31:0]         max_bytes_r;
  logic [EVN_W-1:0]    n_r, n_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  rslt_t               out_r, out_nxt, pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;

  logic [NCELL-1:0]    valid_vec;
  logic [CNT_W-1:0]    count, limit_n;
  logic [31:0]         budget;
  logic                m_any, f_any, ofree, accept, over_lim, evict;
  logic [IDX_W-1:0]    m_idx, f_idx;
  logic [31:0]         m_bytes, p_bytes;

  always_comb begin
    for (int i = 0; i < NCELL; i++) valid_vec[i] = ent[i].valid;
  end
  assign count  = CNT_W'($countones(valid_vec));
  assign budget = (max_bytes_r == 32'd0) ? 32'd1 : max_bytes_r;
  always_comb begin
    if (max_ent_r == 4'd0) limit_n = CNT_W'(1);
    else if (int'(max_ent_r) > ENTRIES) limit_n = CNT_W'(ENTRIES);
    else limit_n = CNT_W'(max_ent_r);
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    m_any = 1'b0;
    m_idx = '0;
    f_any = 1'b0;
    f_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (ent[i].valid && ent[i].key == key_r) begin
        m_any = 1'b1;
        m_idx = IDX_W'(i);
      end
      if (!ent[i].valid) begin
        f_any = 1'b1;
        f_idx = IDX_W'(i);
      end
    end
  end
  assign m_bytes  = ent[m_idx].bytes;
  assign p_bytes  = ent[cand.idx].bytes;
  assign ofree    = !out_valid_r || rsp_ready;
  assign req_ready = (state_r == S_IDLE);
  assign accept   = req_valid && req_ready;
  assign over_lim = (count > limit_n) || (total_r > {1'b0, budget});
  assign evict    = (int'(n_r) < ENTRIES) && over_lim && cand.found;
  assign pin      = '{valid: pin_valid_r, key: pin_key_r, multi: (count > CNT_W'(1))};

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    bytes_nxt      = bytes_r;
    stamp_nxt      = stamp_r;
    total_nxt      = total_r;
    pin_key_nxt    = pin_key_r;
    pin_valid_nxt  = pin_valid_r;
    n_nxt          = n_r;
    wait_nxt       = wait_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !rsp_ready;
    wr             = '{key: key_r, bytes: bytes_r, stamp: stamp_r + 32'd1};
    for (int i = 0; i < NCELL; i++) ctl[i] = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt   = req_action;
          key_nxt   = req_key;
          bytes_nxt = req_bytes;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ofree) begin
          unique case (act_r)
            ACT_CLR: begin
              for (int i = 0; i < NCELL; i++) ctl[i].clr = 1'b1;
              total_nxt     = '0;
              stamp_nxt     = '0;
              pin_key_nxt   = '0;
              pin_valid_nxt = 1'b0;
              out_nxt       = '{OC_DONE, key_r, 32'd0, 33'd0, 1'b1};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
            ACT_LOOK: begin
              pin_key_nxt   = key_r;
              pin_valid_nxt = 1'b1;
              if (m_any) begin
                stamp_nxt = stamp_r + 32'd1;
                ctl[m_idx].stamp_ld = 1'b1;
                out_nxt = '{OC_HIT, key_r, m_bytes, total_r, 1'b1};
              end else begin
                out_nxt = '{OC_MISS, key_r, 32'd0, total_r, 1'b1};
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
            ACT_REM: begin
              if (m_any) begin
                ctl[m_idx].clr = 1'b1;
                total_nxt = total_r - {1'b0, m_bytes};
                out_nxt   = '{OC_DONE, key_r, m_bytes, total_r - {1'b0, m_bytes}, 1'b1};
              end else begin
                out_nxt = '{OC_MISS, key_r, 32'd0, total_r, 1'b1};
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
            default: begin
              // insert: drop any older entry of the same key first
              if (m_any) begin
                ctl[m_idx].clr = 1'b1;
                total_nxt = total_r - {1'b0, m_bytes};
              end
              state_nxt = S_INS;
            end
          endcase
        end
      end
      S_INS: begin
        if (bytes_r > budget) begin
          if (ofree) begin
            out_nxt       = '{OC_REJ, key_r, bytes_r, total_r, 1'b1};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          stamp_nxt        = stamp_r + 32'd1;
          ctl[STAGE].ld    = 1'b1;
          total_nxt        = total_r + {1'b0, bytes_r};
          n_nxt            = '0;
          wait_nxt         = '0;
          pend_valid_nxt   = 1'b0;
          state_nxt        = S_WAIT;
        end
      end
      S_WAIT: begin
        // let the candidate ripple through the whole row
        wait_nxt = wait_r + WAIT_W'(1);
        if (wait_r == WAIT_W'(WAIT_LEN - 1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (ofree) begin
          if (evict) begin
            ctl[cand.idx].clr = 1'b1;
            total_nxt = total_r - {1'b0, p_bytes};
            pend_nxt  = '{OC_EVICT, ent[cand.idx].key, p_bytes,
                          total_r - {1'b0, p_bytes}, 1'b0};
            if (pend_valid_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_valid_nxt = 1'b1;
            n_nxt          = n_r + EVN_W'(1);
            wait_nxt       = '0;
            state_nxt      = S_WAIT;
          end else begin
            if (pend_valid_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b1;
            end else begin
              out_nxt = '{OC_DONE, key_r, bytes_r, total_r, 1'b1};
            end
            out_valid_nxt  = 1'b1;
            pend_valid_nxt = 1'b0;
            // move the staged entry into the lowest free slot
            wr = '{key: ent[STAGE].key, bytes: ent[STAGE].bytes, stamp: ent[STAGE].stamp};
            if (ent[STAGE].valid) begin
              ctl[STAGE].clr = 1'b1;
              if (f_any) ctl[f_idx].ld = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stamp_r      <= '0;
      total_r      <= '0;
      pin_key_r    <= '0;
      pin_valid_r  <= 1'b0;
      max_ent_r    <= DEFAULT_ENTRIES;
      max_bytes_r  <= DEFAULT_BUDGET;
      n_r          <= '0;
      wait_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stamp_r      <= stamp_nxt;
      total_r      <= total_nxt;
      pin_key_r    <= pin_key_nxt;
      pin_valid_r  <= pin_valid_nxt;
      n_r          <= n_nxt;
      wait_r       <= wait_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MAX_ENTRIES: max_ent_r   <= cfg_data[3:0];
          CFG_MAX_BYTES:   max_bytes_r <= cfg_data;
          default: ;
        endcase
      end
    end
    act_r   <= act_nxt;
    key_r   <= key_nxt;
    bytes_r <= bytes_nxt;
    out_r   <= out_nxt;
    pend_r  <= pend_nxt;
  end

  assign rsp_valid = out_valid_r;
  assign rsp       = out_r;

  a_stage_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ent[STAGE].valid)
    else $error("staged entry left behind after a request");
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_WAIT || state_r == S_EVAL))
    else $error("pending eviction outside insert sequence");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count == '0) |-> total_r == '0)
    else $error("held bytes nonzero with empty directory");
  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(n_r) <= ENTRIES)
    else $error("eviction count past bound");
endmodule
`default_nettype wire

>>> src/byte_budget_lru_cache_core.sv
// Top level of the byte-budget LRU cache directory: sequencer plus a row of slot cells.
// Depends on bbl_pkg, bbl_ifs, bbl_cell and bbl_ctrl.
//
//   channel   dir   handshake        payload
//   in_req    in    valid/ready      action, entry_key, entry_bytes
//   out_rsp   out   valid/ready      outcome, out_key, out_bytes, held_bytes, last
//   cfg_*     in    cfg_we           cfg_idx, cfg_data
//
// Lookup, remove and clear go from S_IDLE through S_EXEC to a registered result. An
// insert goes through S_EXEC and S_INS, then S_WAIT and S_EVAL once per eviction pass,
// while the oldest candidate ripples one cell per cycle through the NCELL-cell row.
// Reset is synchronous and empties the directory at once.
// A stalled result holds the sequencer; one request is worked at a time.
`default_nettype none
module byte_budget_lru_cache_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_idx,
  input  wire [31:0] cfg_data,
  bbl_req_if.sink    in_req,
  bbl_rsp_if.source  out_rsp
);
  import bbl_pkg::*;

  entry_t    ent   [NCELL];
  cand_t     chain [NCELL+1];
  cell_ctl_t ctl   [NCELL];
  wr_t       wr;
  pin_t      pin;
  rslt_t     rsp;

  assign chain[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    bbl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (IDX_W'(g)),
      .ctl     (ctl[g]),
      .wr      (wr),
      .pin     (pin),
      .cand_in (chain[g]),
      .ent     (ent[g]),
      .cand_out(chain[g+1])
    );
  end

  bbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req_action(in_req.action),
    .req_key   (in_req.entry_key),
    .req_bytes (in_req.entry_bytes),
    .rsp_valid (out_rsp.valid),
    .rsp_ready (out_rsp.ready),
    .rsp       (rsp),
    .ent       (ent),
    .cand      (chain[NCELL]),
    .ctl       (ctl),
    .wr        (wr),
    .pin       (pin)
  );

  assign out_rsp.outcome    = rsp.outcome;
  assign out_rsp.out_key    = rsp.key;
  assign out_rsp.out_bytes  = rsp.bytes;
  assign out_rsp.held_bytes = rsp.held;
  assign out_rsp.last       = rsp.last;
endmodule
`default_nettype wire
